>>> src/rrr_pkg.sv
// shared constants and types for the ray reflect/refract pipeline
package rrr_pkg;

  // wide signed datapath width and product saturation level (2^46)
  localparam int unsigned QW = 48;
  localparam int unsigned RW = 49;
  localparam logic [46:0] SAT_MAG = 47'h4000_0000_0000;

  localparam int unsigned MUL_LAT = 3;

  localparam logic [1:0] MODE_REFLECT = 2'd0;
  localparam logic [1:0] MODE_REFRACT = 2'd1;

  localparam logic [1:0] OUT_FORWARD = 2'd0;
  localparam logic [1:0] OUT_BACK    = 2'd1;
  localparam logic [1:0] OUT_TIR     = 2'd2;

  localparam logic [1:0] ST_TRANSMIT = 2'd0;
  localparam logic [1:0] ST_SPECULAR = 2'd1;
  localparam logic [1:0] ST_UNCLASS  = 2'd2;
  localparam logic [1:0] ST_TIR      = 2'd3;

  typedef struct packed {
    logic       valid;
    logic [1:0] mode;
  } ctl_t;

endpackage

>>> src/rrr_pipe.sv
// delay line of registers for payload or control beats
module rrr_pipe #(
  parameter int unsigned W   = 1,
  parameter int unsigned D   = 1,
  parameter bit          RST = 1'b0
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] stg_q [D];

  if (RST) begin : g_rst
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        for (int i = 0; i < D; i++) stg_q[i] <= '0;
      end else begin
        stg_q[0] <= d_i;
        for (int i = 1; i < D; i++) stg_q[i] <= stg_q[i-1];
      end
    end
  end else begin : g_nrst
    always_ff @(posedge clk_i) begin
      stg_q[0] <= d_i;
      for (int i = 1; i < D; i++) stg_q[i] <= stg_q[i-1];
    end
  end

  assign q_o = stg_q[D-1];

endmodule

>>> src/rrr_mulq.sv
// three-stage signed fixed-point multiplier with rounding and saturation
module rrr_mulq #(
  parameter int unsigned AW   = 16,
  parameter int unsigned BW   = 16,
  parameter int unsigned FRAC = 14
) (
  input  logic                        clk_i,
  input  logic signed [AW-1:0]        a_i,
  input  logic signed [BW-1:0]        b_i,
  output logic signed [rrr_pkg::QW-1:0] p_o
);
  import rrr_pkg::*;

  localparam int unsigned AL = AW / 2;
  localparam int unsigned AH = AW - AL;
  localparam int unsigned BL = BW / 2;
  localparam int unsigned BH = BW - BL;
  localparam int unsigned PW = AW + BW;
  localparam int unsigned CW = PW + 49;

  logic [AW-1:0] ma;
  logic [BW-1:0] mb;
  logic [AL+BL-1:0] ll_q;
  logic [AL+BH-1:0] lh_q;
  logic [AH+BL-1:0] hl_q;
  logic [AH+BH-1:0] hh_q;
  logic neg1_q, neg2_q;
  logic [PW-1:0] prod_d, prod_q;
  logic [PW:0] rnd;
  logic [CW-1:0] shx;
  logic [46:0] mag;
  logic signed [QW-1:0] p_d, p_q;

  assign ma = a_i[AW-1] ? AW'(-a_i) : AW'(a_i);
  assign mb = b_i[BW-1] ? BW'(-b_i) : BW'(b_i);

  // partial products
  always_ff @(posedge clk_i) begin
    neg1_q <= a_i[AW-1] ^ b_i[BW-1];
    ll_q   <= ma[AL-1:0] * mb[BL-1:0];
    lh_q   <= ma[AL-1:0] * mb[BW-1:BL];
    hl_q   <= ma[AW-1:AL] * mb[BL-1:0];
    hh_q   <= ma[AW-1:AL] * mb[BW-1:BL];
  end

  assign prod_d = PW'(ll_q) + (PW'(lh_q) << BL) + (PW'(hl_q) << AL)
                + (PW'(hh_q) << (AL + BL));

  always_ff @(posedge clk_i) begin
    neg2_q <= neg1_q;
    prod_q <= prod_d;
  end

  // round half away from zero, saturate magnitude
  assign rnd = {1'b0, prod_q} + ((PW+1)'(1) << (FRAC - 1));
  assign shx = CW'(rnd >> FRAC);
  assign mag = (shx > CW'(SAT_MAG)) ? SAT_MAG : shx[46:0];
  assign p_d = neg2_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

>>> src/rrr_div.sv
// pipelined restoring divider for the index ratio, one quotient bit a stage
module rrr_div #(
  parameter int unsigned IW   = 16,
  parameter int unsigned FRAC = 14
) (
  input  logic          clk_i,
  input  logic [IW-1:0] num_i,
  input  logic [IW-1:0] den_i,
  output logic [46:0]   nn_o
);
  import rrr_pkg::*;

  localparam int unsigned XW = IW + FRAC + 1;

  logic [XW-1:0] x_q   [XW+1];
  logic [XW-1:0] q_q   [XW+1];
  logic [IW-1:0] rem_q [XW+1];
  logic [IW-1:0] den_q [XW+1];
  logic [46:0]   nn_q;
  logic [63:0]   qx;

  // dividend with half divisor added for round half up
  always_ff @(posedge clk_i) begin
    x_q[0]   <= XW'({num_i, {FRAC{1'b0}}}) + XW'(den_i >> 1);
    q_q[0]   <= '0;
    rem_q[0] <= '0;
    den_q[0] <= den_i;
  end

  for (genvar s = 0; s < XW; s++) begin : g_stage
    logic [IW:0] trial;
    logic        ge;
    assign trial = {rem_q[s], x_q[s][XW-1]};
    assign ge    = trial >= {1'b0, den_q[s]};
    always_ff @(posedge clk_i) begin
      rem_q[s+1] <= ge ? IW'(trial - {1'b0, den_q[s]}) : trial[IW-1:0];
      x_q[s+1]   <= x_q[s] << 1;
      q_q[s+1]   <= {q_q[s][XW-2:0], ge};
      den_q[s+1] <= den_q[s];
    end
  end

  assign qx = 64'(q_q[XW]);

  always_ff @(posedge clk_i) begin
    nn_q <= ((den_q[XW] == '0) || (qx > 64'(SAT_MAG))) ? SAT_MAG : qx[46:0];
  end

  assign nn_o = nn_q;

endmodule

>>> src/rrr_sqrt.sv
// pipelined digit-by-digit integer square root, one root bit a stage
module rrr_sqrt #(
  parameter int unsigned FRAC = 14
) (
  input  logic              clk_i,
  input  logic [FRAC+3:0]   u_i,
  output logic [FRAC+1:0]   root_o
);

  localparam int unsigned R  = FRAC + 2;
  localparam int unsigned EW = R + 3;

  logic [2*R-1:0] x_q    [R+1];
  logic [EW-1:0]  rem_q  [R+1];
  logic [R-1:0]   root_q [R+1];

  assign x_q[0]    = {u_i, {FRAC{1'b0}}};
  assign rem_q[0]  = '0;
  assign root_q[0] = '0;

  for (genvar s = 0; s < R; s++) begin : g_stage
    logic [EW-1:0] cur;
    logic [EW-1:0] trial;
    logic          ge;
    assign cur   = {rem_q[s][R:0], x_q[s][2*R-1:2*R-2]};
    assign trial = EW'({root_q[s], 2'b01});
    assign ge    = cur >= trial;
    always_ff @(posedge clk_i) begin
      rem_q[s+1]  <= ge ? (cur - trial) : cur;
      root_q[s+1] <= {root_q[s][R-2:0], ge};
      x_q[s+1]    <= x_q[s] << 2;
    end
  end

  assign root_o = root_q[R];

endmodule

>>> src/ray_reflect_refract.sv
// top level: photon direction reflection, refraction and classification pipeline
//
// Input channel: an item (mode, direction, normal, two indices) is taken at
// every rising edge with start high and busy low. busy stays low: a new item
// may enter in every cycle and many items are in flight at once.
// Result channel: done_o is high for exactly one cycle with out_x_o..z_o,
// outcome_o and status_code_o; the receiver takes the beat at the edge that
// ends that cycle and cannot hold it off.
// The delay from the accepting edge to the edge that takes the result is the
// same for every mode. It is set mostly by the index ratio divider, which
// retires one quotient bit per stage (INDEX_WIDTH + VEC_WIDTH - 1 stages),
// and the square root, which retires one root bit per stage (VEC_WIDTH
// stages), plus three chained three-stage multipliers.
// Throughput: one item per cycle.
// Reset: clears the valid and mode bits of the pipeline only; items in flight are
// dropped and no result appears until new items reach the end.
module ray_reflect_refract #(
  parameter int unsigned VEC_WIDTH   = 16,
  parameter int unsigned INDEX_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    mode_i,
  input  logic signed [VEC_WIDTH-1:0]   dir_x_i,
  input  logic signed [VEC_WIDTH-1:0]   dir_y_i,
  input  logic signed [VEC_WIDTH-1:0]   dir_z_i,
  input  logic signed [VEC_WIDTH-1:0]   normal_x_i,
  input  logic signed [VEC_WIDTH-1:0]   normal_y_i,
  input  logic signed [VEC_WIDTH-1:0]   normal_z_i,
  input  logic [INDEX_WIDTH-1:0]        index_from_i,
  input  logic [INDEX_WIDTH-1:0]        index_to_i,
  output logic                          done_o,
  output logic signed [VEC_WIDTH-1:0]   out_x_o,
  output logic signed [VEC_WIDTH-1:0]   out_y_o,
  output logic signed [VEC_WIDTH-1:0]   out_z_o,
  output logic [1:0]                    outcome_o,
  output logic [1:0]                    status_code_o
);
  import rrr_pkg::*;

  localparam int unsigned VW      = VEC_WIDTH;
  localparam int unsigned IW      = INDEX_WIDTH;
  localparam int unsigned F       = VW - 2;
  localparam int unsigned DW      = VW + 3;
  localparam int unsigned R       = F + 2;
  localparam int unsigned UW      = F + 4;
  localparam int unsigned XW      = IW + F + 1;
  localparam int unsigned T_A     = XW + 2;
  localparam int unsigned T_B     = T_A + MUL_LAT;
  localparam int unsigned T_C     = T_B + MUL_LAT;
  localparam int unsigned T_D     = T_C + 1 + R;
  localparam int unsigned T_E     = T_D + 1 + MUL_LAT;
  localparam int unsigned LAT     = T_E + 2;

  localparam logic [QW-1:0] ONE_Q = QW'(1) << F;
  localparam logic [QW-1:0] U_MAX = QW'(8) << F;
  localparam logic [RW-1:0] ONE_R = RW'(1) << F;

  // input register
  ctl_t            ctl0_q;
  logic [3*VW-1:0] v0_q, n0_q;
  logic [IW-1:0]   nfrom_q, nto_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl0_q <= '0;
    end else begin
      ctl0_q.valid <= start & ~busy;
      ctl0_q.mode  <= mode_i;
    end
  end

  always_ff @(posedge clk_i) begin
    v0_q    <= {dir_z_i, dir_y_i, dir_x_i};
    n0_q    <= {normal_z_i, normal_y_i, normal_x_i};
    nfrom_q <= index_from_i;
    nto_q   <= index_to_i;
  end

  assign busy = 1'b0;

  // dot product
  logic signed [QW-1:0] pd [3];
  logic signed [DW-1:0] d_q, d_a;

  for (genvar i = 0; i < 3; i++) begin : g_dot
    rrr_mulq #(.AW(VW), .BW(VW), .FRAC(F)) u_mul (
      .clk_i(clk_i), .a_i(n0_q[i*VW +: VW]), .b_i(v0_q[i*VW +: VW]), .p_o(pd[i])
    );
  end

  always_ff @(posedge clk_i) begin
    d_q <= DW'(pd[0] + pd[1] + pd[2]);
  end

  // index ratio
  logic [46:0] nn;

  rrr_div #(.IW(IW), .FRAC(F)) u_div (
    .clk_i(clk_i), .num_i(nfrom_q), .den_i(nto_q), .nn_o(nn)
  );

  // alignment to the ratio
  logic [3*VW-1:0] v_a, n_a, v_e, n_t;
  ctl_t            ctl_e;

  rrr_pipe #(.W(DW), .D(T_A - 4)) u_pd (
    .clk_i(clk_i), .rst_ni(rst_ni), .d_i(d_q), .q_o(d_a)
  );
  rrr_pipe #(.W(3*VW), .D(T_A)) u_pv0 (
    .clk_i(clk_i), .rst_ni(rst_ni), .d_i(v0_q), .q_o(v_a)
  );
  rrr_pipe #(.W(3*VW), .D(T_A)) u_pn0 (
    .clk_i(clk_i), .rst_ni(rst_ni), .d_i(n0_q), .q_o(n_a)
  );
  rrr_pipe #(.W($bits(ctl_t)), .D(T_E), .RST(1'b1)) u_pctl (
    .clk_i(clk_i), .rst_ni(rst_ni), .d_i(ctl0_q), .q_o(ctl_e)
  );

  // first product layer
  logic signed [QW-1:0] nn_s, nn2, dd, nd, nd_d;
  logic signed [QW-1:0] nv [3];
  logic signed [QW-1:0] rn [3];
  logic [3*QW-1:0] nv_b, rn_b, nv_e, rn_e;

  assign nn_s = $signed({1'b0, nn});

  rrr_mulq #(.AW(QW), .BW(QW), .FRAC(F)) u_nn2 (
    .clk_i(clk_i), .a_i(nn_s), .b_i(nn_s), .p_o(nn2)
  );
  rrr_mulq #(.AW(DW), .BW(DW), .FRAC(F)) u_dd (
    .clk_i(clk_i), .a_i(d_a), .b_i(d_a), .p_o(dd)
  );
  rrr_mulq #(.AW(QW), .BW(DW), .FRAC(F)) u_nd (
    .clk_i(clk_i), .a_i(nn_s), .b_i(d_a), .p_o(nd)
  );

  for (genvar i = 0; i < 3; i++) begin : g_lay1
    rrr_mulq #(.AW(QW), .BW(VW), .FRAC(F)) u_nv (
      .clk_i(clk_i), .a_i(nn_s), .b_i(v_a[i*VW +: VW]), .p_o(nv[i])
    );
    rrr_mulq #(.AW(DW), .BW(VW), .FRAC(F)) u_rn (
      .clk_i(clk_i), .a_i(d_a), .b_i(n_a[i*VW +: VW]), .p_o(rn[i])
    );
    assign nv_b[i*QW +: QW] = nv[i];
    assign rn_b[i*QW +: QW] = rn[i];
  end

  logic d_neg_e;

  rrr_pipe #(.W(1), .D(T_E - T_A)) u_pdn (
    .clk_i(clk_i), .rst_ni(rst_ni), .d_i(d_a[DW-1]), .q_o(d_neg_e)
  );
  rrr_pipe #(.W(3*VW), .D(T_E - T_A)) u_pv1 (
    .clk_i(clk_i), .rst_ni(rst_ni), .d_i(v_a), .q_o(v_e)
  );
  rrr_pipe #(.W(3*VW), .D(T_D + 1 - T_A)) u_pn1 (
    .clk_i(clk_i), .rst_ni(rst_ni), .d_i(n_a), .q_o(n_t)
  );
  rrr_pipe #(.W(3*QW), .D(T_E - T_B)) u_pnv (
    .clk_i(clk_i), .rst_ni(rst_ni), .d_i(nv_b), .q_o(nv_e)
  );
  rrr_pipe #(.W(3*QW), .D(T_E - T_B)) u_prn (
    .clk_i(clk_i), .rst_ni(rst_ni), .d_i(rn_b), .q_o(rn_e)
  );
  rrr_pipe #(.W(QW), .D(T_D - T_B)) u_pnd (
    .clk_i(clk_i), .rst_ni(rst_ni), .d_i(nd), .q_o(nd_d)
  );

  // radicand
  logic signed [QW-1:0] w, p, u;
  logic          u_neg_q, u_neg_e;
  logic [UW-1:0] ucl_q;

  assign w = $signed(ONE_Q) - dd;

  rrr_mulq #(.AW(QW), .BW(QW), .FRAC(F)) u_p (
    .clk_i(clk_i), .a_i(nn2), .b_i(w), .p_o(p)
  );

  assign u = $signed(ONE_Q) - p;

  always_ff @(posedge clk_i) begin
    u_neg_q <= u[QW-1];
    ucl_q   <= (u > $signed(U_MAX)) ? U_MAX[UW-1:0] : u[UW-1:0];
  end

  rrr_pipe #(.W(1), .D(T_E - T_C - 1)) u_pun (
    .clk_i(clk_i), .rst_ni(rst_ni), .d_i(u_neg_q), .q_o(u_neg_e)
  );

  logic [R-1:0] root;

  rrr_sqrt #(.FRAC(F)) u_sqrt (
    .clk_i(clk_i), .u_i(ucl_q), .root_o(root)
  );

  // refraction term
  logic signed [QW-1:0] t_q;
  logic signed [QW-1:0] tn [3];

  always_ff @(posedge clk_i) begin
    t_q <= nd_d - $signed(QW'(root));
  end

  for (genvar i = 0; i < 3; i++) begin : g_lay3
    rrr_mulq #(.AW(QW), .BW(VW), .FRAC(F)) u_tn (
      .clk_i(clk_i), .a_i(t_q), .b_i(n_t[i*VW +: VW]), .p_o(tn[i])
    );
  end

  // result select and clamp
  logic signed [RW-1:0] res [3];
  logic signed [VW-1:0] cl  [3];
  logic [1:0] outcome_d, status_d;

  always_comb begin
    outcome_d = OUT_FORWARD;
    status_d  = ST_TRANSMIT;
    for (int i = 0; i < 3; i++) begin
      res[i] = {{(RW-VW){v_e[i*VW+VW-1]}}, v_e[i*VW +: VW]};
    end
    unique case (ctl_e.mode)
      MODE_REFLECT: begin
        outcome_d = OUT_BACK;
        status_d  = ST_SPECULAR;
        for (int i = 0; i < 3; i++) begin
          res[i] = res[i] - $signed({rn_e[i*QW +: QW], 1'b0});
        end
      end
      MODE_REFRACT: begin
        if (u_neg_e) begin
          outcome_d = OUT_TIR;
          status_d  = ST_TIR;
        end else begin
          for (int i = 0; i < 3; i++) begin
            res[i] = $signed({nv_e[i*QW+QW-1], nv_e[i*QW +: QW]})
                   - $signed({tn[i][QW-1], tn[i]});
          end
        end
      end
      default: begin
        if (d_neg_e) begin
          outcome_d = OUT_BACK;
          status_d  = ST_UNCLASS;
        end
      end
    endcase
    for (int i = 0; i < 3; i++) begin
      if (res[i] > $signed(ONE_R)) begin
        cl[i] = VW'(ONE_R);
      end else if (res[i] < -$signed(ONE_R)) begin
        cl[i] = VW'(-$signed(ONE_R));
      end else begin
        cl[i] = res[i][VW-1:0];
      end
    end
  end

  logic done_q;
  logic signed [VW-1:0] ox_q, oy_q, oz_q;
  logic [1:0] outcome_q, status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctl_e.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    ox_q      <= cl[0];
    oy_q      <= cl[1];
    oz_q      <= cl[2];
    outcome_q <= outcome_d;
    status_q  <= status_d;
  end

  assign done_o        = done_q;
  assign out_x_o       = ox_q;
  assign out_y_o       = oy_q;
  assign out_z_o       = oz_q;
  assign outcome_o     = outcome_q;
  assign status_code_o = status_q;

  // every accepted beat comes out after a fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##LAT done_o)
    else $error("result beat missing");

  a_tir_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((outcome_o == OUT_TIR) == (status_code_o == ST_TIR)))
    else $error("internal reflection codes disagree");

  a_spec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_code_o == ST_SPECULAR |-> outcome_o == OUT_BACK)
    else $error("specular beat not marked back");

  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (out_x_o <= $signed(VW'(ONE_R)) && out_x_o >= -$signed(VW'(ONE_R))))
    else $error("x component outside saturation range");

endmodule
